// ===== rtl/cpa_pkg.sv =====
// Package for the CRC parity appender: generator constants, mode codes,
// the queue entry type and the bytewise CRC update function.
// Used by every module under rtl; depends on nothing.
package cpa_pkg;

  localparam logic [1:0] MODE_CRC24A = 2'd0;
  localparam logic [1:0] MODE_CRC24B = 2'd1;
  localparam logic [1:0] MODE_CRC16  = 2'd2;
  localparam logic [1:0] MODE_CRC16B = 2'd3;

  localparam logic [23:0] POLY_CRC24A = 24'h864CFB;
  localparam logic [23:0] POLY_CRC24B = 24'h800063;
  localparam logic [23:0] POLY_CRC16  = 24'h001021;
  localparam logic [23:0] MASK_CRC24  = 24'hFFFFFF;
  localparam logic [23:0] MASK_CRC16  = 24'h00FFFF;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [1:0] PHASE_DATA = 2'd0;
  localparam logic [1:0] PHASE_LAST = 2'd3;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        is16;
    logic [23:0] crc;
  } cpa_entry_t;

  function automatic logic mode_is_16(input logic [1:0] mode);
    return mode[1];
  endfunction

  function automatic logic [23:0] poly_of(input logic [1:0] mode);
    logic [23:0] p;
    case (mode)
      MODE_CRC24A: p = POLY_CRC24A;
      MODE_CRC24B: p = POLY_CRC24B;
      MODE_CRC16:  p = POLY_CRC16;
      MODE_CRC16B: p = POLY_CRC16;
      default:     p = POLY_CRC16;
    endcase
    return p;
  endfunction

  // One message byte, MSB first, through the selected generator.
  function automatic logic [23:0] crc_feed(input logic [23:0] rem,
                                           input logic [7:0] data,
                                           input logic [1:0] mode);
    logic [23:0] r;
    logic [23:0] mask;
    logic [23:0] poly;
    logic        top;
    mask = mode_is_16(mode) ? MASK_CRC16 : MASK_CRC24;
    poly = poly_of(mode);
    if (mode_is_16(mode)) begin
      r = (rem & mask) ^ {8'd0, data, 8'd0};
    end else begin
      r = (rem & mask) ^ {data, 16'd0};
    end
    for (int k = 0; k < 8; k++) begin
      top = mode_is_16(mode) ? r[15] : r[23];
      r = ({r[22:0], 1'b0} ^ (top ? poly : 24'd0)) & mask;
    end
    return r;
  endfunction

endpackage

// ===== rtl/crc_parity_appender.sv =====
// Top level of the CRC parity appender (CRC24A, CRC24B and CRC16 of 3GPP LTE).
// Instantiates the front end, the queue and the back end; depends on cpa_pkg.
//
// Usage:
//   Input channel: a message byte beat is taken when push is high and full is
//   low; in_last_byte marks the final byte of a message.
//   Result channel: while empty is low the oldest beat sits on out_byte,
//   out_is_parity and out_last; it is taken when pop is high.
//   Every message byte comes out unchanged. After the last byte follow the
//   parity bytes, most significant first: three for CRC24A or CRC24B, two
//   for CRC16, the final one with out_last set. The CRC starts at zero and
//   has no final XOR.
//   Configuration: cfg_wr_data selects the generator at a clock edge with
//   cfg_wr_en high. The user must do this only while no beat is in flight;
//   the block does not enforce it. Inside a message the remainder is kept and
//   the new generator applies from the next byte on.
//   Throughput: one beat per cycle on each side while full is low and pop high,
//   set by the single output register of the back end.
//   When the receiver stalls, the queue fills and full rises; nothing is lost.
//   Reset clears the remainder, the queue and the output, and selects CRC24A.
module crc_parity_appender #(
  parameter int unsigned QDEPTH = cpa_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_is_parity,
  output logic       out_last
);

  cpa_pkg::cpa_entry_t q_wr_data;
  cpa_pkg::cpa_entry_t q_rd_data;
  logic                q_wr_en;
  logic                q_rd_en;
  logic                q_full;
  logic                q_empty;

  assign full = q_full;

  cpa_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .push         (push),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .q_full       (q_full),
    .q_wr_en      (q_wr_en),
    .q_wr_data    (q_wr_data)
  );

  cpa_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr_en),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd_en   (q_rd_en),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  cpa_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_rd_data     (q_rd_data),
    .q_empty       (q_empty),
    .q_rd_en       (q_rd_en),
    .empty         (empty),
    .pop           (pop),
    .out_byte      (out_byte),
    .out_is_parity (out_is_parity),
    .out_last      (out_last)
  );

endmodule

// ===== rtl/cpa_front.sv =====
// Front end of the CRC parity appender: holds the mode register and the running
// remainder, and turns each accepted byte into a queue entry with its CRC snapshot.
// Depends on cpa_pkg.
module cpa_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_wr_data,
  input  logic               push,
  input  logic [7:0]         in_data_byte,
  input  logic               in_last_byte,
  input  logic               q_full,
  output logic               q_wr_en,
  output cpa_pkg::cpa_entry_t q_wr_data
);

  logic [1:0]  crc_mode_r;
  logic [23:0] rem_r;
  logic [23:0] rem_nxt;
  logic [23:0] fed;

  assign q_wr_en = push && !q_full;
  assign fed     = cpa_pkg::crc_feed(rem_r, in_data_byte, crc_mode_r);

  always_comb begin
    rem_nxt = rem_r;
    if (q_wr_en) begin
      rem_nxt = in_last_byte ? 24'd0 : fed;
    end
  end

  always_comb begin
    q_wr_data.data = in_data_byte;
    q_wr_data.last = in_last_byte;
    q_wr_data.is16 = cpa_pkg::mode_is_16(crc_mode_r);
    q_wr_data.crc  = fed;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_mode_r <= cpa_pkg::MODE_CRC24A;
      rem_r      <= 24'd0;
    end else begin
      if (cfg_wr_en) begin
        crc_mode_r <= cfg_wr_data;
      end
      rem_r <= rem_nxt;
    end
  end

endmodule

// ===== rtl/cpa_queue.sv =====
// Short queue between the front and back ends of the CRC parity appender.
// Holds classified byte entries; depends on cpa_pkg.
module cpa_queue #(
  parameter int unsigned DEPTH = cpa_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  cpa_pkg::cpa_entry_t wr_data,
  output logic                full,
  input  logic                rd_en,
  output cpa_pkg::cpa_entry_t rd_data,
  output logic                empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cpa_pkg::cpa_entry_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_rd) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/cpa_back.sv =====
// Back end of the CRC parity appender: expands each queue entry into its message
// beat and, for the last byte, its parity beats, into the output register.
// Depends on cpa_pkg.
module cpa_back (
  input  logic                clk,
  input  logic                rst_n,
  input  cpa_pkg::cpa_entry_t q_rd_data,
  input  logic                q_empty,
  output logic                q_rd_en,
  output logic                empty,
  input  logic                pop,
  output logic [7:0]          out_byte,
  output logic                out_is_parity,
  output logic                out_last
);

  logic       ov_r;
  logic [7:0] byte_r;
  logic       par_r;
  logic       last_r;
  logic [1:0] phase_r;
  logic [1:0] phase_nxt;
  logic [1:0] sel;
  logic       load;
  logic       entry_done;
  logic [7:0] byte_nxt;

  assign load = (!ov_r || pop) && !q_empty;

  // In CRC16 mode the two parity beats use the lower two byte slots.
  always_comb begin
    if (phase_r != cpa_pkg::PHASE_DATA && q_rd_data.is16) begin
      sel = phase_r + 2'd1;
    end else begin
      sel = phase_r;
    end
  end

  always_comb begin
    case (sel)
      2'd0:    byte_nxt = q_rd_data.data;
      2'd1:    byte_nxt = q_rd_data.crc[23:16];
      2'd2:    byte_nxt = q_rd_data.crc[15:8];
      2'd3:    byte_nxt = q_rd_data.crc[7:0];
      default: byte_nxt = q_rd_data.data;
    endcase
  end

  assign entry_done = (phase_r == cpa_pkg::PHASE_DATA) ? !q_rd_data.last
                                                       : (sel == cpa_pkg::PHASE_LAST);
  assign q_rd_en    = load && entry_done;

  always_comb begin
    phase_nxt = phase_r;
    if (load) begin
      phase_nxt = entry_done ? cpa_pkg::PHASE_DATA : phase_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= byte_nxt;
      par_r  <= (phase_r != cpa_pkg::PHASE_DATA);
      last_r <= (sel == cpa_pkg::PHASE_LAST);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r    <= 1'b0;
      phase_r <= cpa_pkg::PHASE_DATA;
    end else begin
      phase_r <= phase_nxt;
      if (load) begin
        ov_r <= 1'b1;
      end else if (pop) begin
        ov_r <= 1'b0;
      end
    end
  end

  assign empty         = !ov_r;
  assign out_byte      = byte_r;
  assign out_is_parity = par_r;
  assign out_last      = last_r;

endmodule
